FILE: design/mts_pkg.sv
package mts_pkg;

	// Table geometry
	localparam int unsigned TABLE_DEPTH = 65536;
	localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int unsigned TOP_MAX     = (TABLE_DEPTH - 1 < 65535) ? TABLE_DEPTH - 1 : 65535;

	localparam int unsigned IDX_W   = 16;
	localparam int unsigned J_W     = 17;
	localparam int unsigned I_W     = 9;
	localparam int unsigned SQ_W    = 17;
	localparam int unsigned ENTRY_W = 18;

	typedef logic signed [ENTRY_W-1:0] entry_t;

	// Result status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_RANGE   = 2'd1;
	localparam logic [1:0] STAT_UNBUILT = 2'd2;
	localparam logic [1:0] STAT_BUILT   = 2'd3;

	// Input modes
	localparam logic MODE_BUILD = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	// Dispatch codes at item acceptance
	localparam logic [1:0] DISP_BUILD  = 2'd0;
	localparam logic [1:0] DISP_READ   = 2'd1;
	localparam logic [1:0] DISP_REJECT = 2'd2;

	// Program step addresses
	localparam int unsigned PC_W = 5;
	localparam logic [PC_W-1:0] ST_IDLE     = 5'd0;
	localparam logic [PC_W-1:0] ST_INIT     = 5'd1;
	localparam logic [PC_W-1:0] ST_FILL_CHK = 5'd2;
	localparam logic [PC_W-1:0] ST_FILL     = 5'd3;
	localparam logic [PC_W-1:0] ST_SETI     = 5'd4;
	localparam logic [PC_W-1:0] ST_SQ       = 5'd5;
	localparam logic [PC_W-1:0] ST_TST_SQ   = 5'd6;
	localparam logic [PC_W-1:0] ST_TST_PRM  = 5'd7;
	localparam logic [PC_W-1:0] ST_M_CHK    = 5'd8;
	localparam logic [PC_W-1:0] ST_M_RD     = 5'd9;
	localparam logic [PC_W-1:0] ST_M_MUL    = 5'd10;
	localparam logic [PC_W-1:0] ST_M_WR     = 5'd11;
	localparam logic [PC_W-1:0] ST_Z_INIT   = 5'd12;
	localparam logic [PC_W-1:0] ST_Z_CHK    = 5'd13;
	localparam logic [PC_W-1:0] ST_Z_WR     = 5'd14;
	localparam logic [PC_W-1:0] ST_NEXTI    = 5'd15;
	localparam logic [PC_W-1:0] ST_MAP_INIT = 5'd16;
	localparam logic [PC_W-1:0] ST_MAP_CHK  = 5'd17;
	localparam logic [PC_W-1:0] ST_MAP_RD   = 5'd18;
	localparam logic [PC_W-1:0] ST_MAP_WR   = 5'd19;
	localparam logic [PC_W-1:0] ST_BDONE    = 5'd20;
	localparam logic [PC_W-1:0] ST_EMIT     = 5'd21;
	localparam logic [PC_W-1:0] ST_RETRY    = 5'd22;
	localparam logic [PC_W-1:0] ST_RDA      = 5'd23;
	localparam logic [PC_W-1:0] ST_RDB      = 5'd24;

	// Jump conditions
	localparam logic [2:0] JC_NONE     = 3'd0;
	localparam logic [2:0] JC_ALWAYS   = 3'd1;
	localparam logic [2:0] JC_J_GT_TOP = 3'd2;
	localparam logic [2:0] JC_SQ_GT_TOP = 3'd3;
	localparam logic [2:0] JC_NOT_ONE  = 3'd4;
	localparam logic [2:0] JC_OUT_FREE = 3'd5;

	// j register operations
	localparam logic [2:0] J_HOLD  = 3'd0;
	localparam logic [2:0] J_ZERO  = 3'd1;
	localparam logic [2:0] J_TWO   = 3'd2;
	localparam logic [2:0] J_I     = 3'd3;
	localparam logic [2:0] J_SQ    = 3'd4;
	localparam logic [2:0] J_INC   = 3'd5;
	localparam logic [2:0] J_ADDI  = 3'd6;
	localparam logic [2:0] J_ADDSQ = 3'd7;

	// i register operations
	localparam logic [1:0] I_HOLD = 2'd0;
	localparam logic [1:0] I_TWO  = 2'd1;
	localparam logic [1:0] I_INC  = 2'd2;

	// Memory operations
	localparam logic [2:0] MEM_NONE    = 3'd0;
	localparam logic [2:0] MEM_RD_J    = 3'd1;
	localparam logic [2:0] MEM_RD_I    = 3'd2;
	localparam logic [2:0] MEM_RD_IDX  = 3'd3;
	localparam logic [2:0] MEM_WR_ONE  = 3'd4;
	localparam logic [2:0] MEM_WR_PROD = 3'd5;
	localparam logic [2:0] MEM_WR_ZERO = 3'd6;
	localparam logic [2:0] MEM_WR_MAP  = 3'd7;

	// Result register actions
	localparam logic [1:0] RES_NONE  = 2'd0;
	localparam logic [1:0] RES_BUILD = 2'd1;
	localparam logic [1:0] RES_READ  = 2'd2;

	typedef struct packed {
		logic [PC_W-1:0] target;
		logic [2:0]      cond;
		logic [2:0]      j_op;
		logic [1:0]      i_op;
		logic            sq_ld;
		logic [2:0]      mem_op;
		logic            prod_ld;
		logic [1:0]      res;
		logic            emit;
	} cw_t;

	typedef struct packed {
		logic j_gt_top;
		logic sq_gt_top;
		logic not_one;
	} dp_flags_t;

endpackage

FILE: design/mts_seq.sv
module mts_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         disp,
	input  mts_pkg::dp_flags_t flags,
	input  logic               out_free,
	output mts_pkg::cw_t       cw,
	output logic               idle
);
	import mts_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	logic            take;

	// Microcode store: one control word per step
	always_comb begin
		cw = '0;
		unique case (pc_q)
			ST_IDLE: begin
			end
			ST_INIT: begin
				cw.j_op = J_ZERO;
			end
			ST_FILL_CHK: begin
				cw.cond   = JC_J_GT_TOP;
				cw.target = ST_SETI;
			end
			ST_FILL: begin
				cw.mem_op = MEM_WR_ONE;
				cw.j_op   = J_INC;
				cw.cond   = JC_ALWAYS;
				cw.target = ST_FILL_CHK;
			end
			ST_SETI: begin
				cw.i_op = I_TWO;
			end
			ST_SQ: begin
				cw.sq_ld  = 1'b1;
				cw.mem_op = MEM_RD_I;
			end
			ST_TST_SQ: begin
				cw.cond   = JC_SQ_GT_TOP;
				cw.target = ST_MAP_INIT;
			end
			ST_TST_PRM: begin
				cw.j_op   = J_I;
				cw.cond   = JC_NOT_ONE;
				cw.target = ST_NEXTI;
			end
			ST_M_CHK: begin
				cw.cond   = JC_J_GT_TOP;
				cw.target = ST_Z_INIT;
			end
			ST_M_RD: begin
				cw.mem_op = MEM_RD_J;
			end
			ST_M_MUL: begin
				cw.prod_ld = 1'b1;
			end
			ST_M_WR: begin
				cw.mem_op = MEM_WR_PROD;
				cw.j_op   = J_ADDI;
				cw.cond   = JC_ALWAYS;
				cw.target = ST_M_CHK;
			end
			ST_Z_INIT: begin
				cw.j_op = J_SQ;
			end
			ST_Z_CHK: begin
				cw.cond   = JC_J_GT_TOP;
				cw.target = ST_NEXTI;
			end
			ST_Z_WR: begin
				cw.mem_op = MEM_WR_ZERO;
				cw.j_op   = J_ADDSQ;
				cw.cond   = JC_ALWAYS;
				cw.target = ST_Z_CHK;
			end
			ST_NEXTI: begin
				cw.i_op   = I_INC;
				cw.cond   = JC_ALWAYS;
				cw.target = ST_SQ;
			end
			ST_MAP_INIT: begin
				cw.j_op = J_TWO;
			end
			ST_MAP_CHK: begin
				cw.cond   = JC_J_GT_TOP;
				cw.target = ST_BDONE;
			end
			ST_MAP_RD: begin
				cw.mem_op = MEM_RD_J;
			end
			ST_MAP_WR: begin
				cw.mem_op = MEM_WR_MAP;
				cw.j_op   = J_INC;
				cw.cond   = JC_ALWAYS;
				cw.target = ST_MAP_CHK;
			end
			ST_BDONE: begin
				cw.res    = RES_BUILD;
				cw.cond   = JC_ALWAYS;
				cw.target = ST_EMIT;
			end
			ST_EMIT: begin
				cw.emit   = 1'b1;
				cw.cond   = JC_OUT_FREE;
				cw.target = ST_IDLE;
			end
			ST_RETRY: begin
				cw.cond   = JC_ALWAYS;
				cw.target = ST_EMIT;
			end
			ST_RDA: begin
				cw.mem_op = MEM_RD_IDX;
			end
			ST_RDB: begin
				cw.res    = RES_READ;
				cw.cond   = JC_ALWAYS;
				cw.target = ST_EMIT;
			end
			default: begin
				cw.cond   = JC_ALWAYS;
				cw.target = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		case (cw.cond)
			JC_ALWAYS:    take = 1'b1;
			JC_J_GT_TOP:  take = flags.j_gt_top;
			JC_SQ_GT_TOP: take = flags.sq_gt_top;
			JC_NOT_ONE:   take = flags.not_one;
			JC_OUT_FREE:  take = out_free;
			default:      take = 1'b0;
		endcase
	end

	assign idle = (pc_q == ST_IDLE);

	always_comb begin
		if (idle) begin
			if (!accept) begin
				pc_next = ST_IDLE;
			end else begin
				unique case (disp)
					DISP_BUILD: pc_next = ST_INIT;
					DISP_READ:  pc_next = ST_RDA;
					default:    pc_next = ST_EMIT;
				endcase
			end
		end else if (take) begin
			pc_next = cw.target;
		end else begin
			pc_next = pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(idle && accept) |=> !idle)
		else $error("sequencer stayed idle after a transaction");

endmodule

FILE: design/mts_datapath.sv
module mts_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mts_pkg::cw_t               cw,
	input  logic                       accept,
	input  logic [mts_pkg::IDX_W-1:0]  index,
	input  logic [mts_pkg::IDX_W-1:0]  eff_top,
	output mts_pkg::dp_flags_t         flags,
	output logic [1:0]                 rd_value
);
	import mts_pkg::*;

	entry_t              mem [TABLE_DEPTH];
	entry_t              rd_q;
	entry_t              prod_q;
	logic [IDX_W-1:0]    top_q;
	logic [IDX_W-1:0]    idx_q;
	logic [J_W-1:0]      j_q;
	logic [I_W-1:0]      i_q;
	logic [SQ_W-1:0]     sq_q;

	logic [ADDR_W-1:0]   addr;
	entry_t              wdata;
	logic                mem_we;
	logic                mem_re;
	logic signed [I_W:0] neg_i;
	logic signed [27:0]  prod_full;
	entry_t              n_pos;
	entry_t              map_val;
	logic [J_W-1:0]      top_ext;

	assign top_ext   = {1'b0, top_q};
	assign neg_i     = -$signed({1'b0, i_q});
	assign prod_full = rd_q * neg_i;
	assign n_pos     = $signed({1'b0, j_q});

	// Fold the raw sieve product into the Moebius value
	always_comb begin
		if (rd_q == n_pos) begin
			map_val = entry_t'(1);
		end else if (rd_q == -n_pos) begin
			map_val = -entry_t'(1);
		end else if (rd_q < 0) begin
			map_val = entry_t'(1);
		end else if (rd_q > 0) begin
			map_val = -entry_t'(1);
		end else begin
			map_val = '0;
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		addr   = ADDR_W'(j_q);
		wdata  = '0;
		case (cw.mem_op)
			MEM_RD_J: begin
				mem_re = 1'b1;
			end
			MEM_RD_I: begin
				mem_re = 1'b1;
				addr   = ADDR_W'(i_q);
			end
			MEM_RD_IDX: begin
				mem_re = 1'b1;
				addr   = ADDR_W'(idx_q);
			end
			MEM_WR_ONE: begin
				mem_we = 1'b1;
				wdata  = entry_t'(1);
			end
			MEM_WR_PROD: begin
				mem_we = 1'b1;
				wdata  = prod_q;
			end
			MEM_WR_ZERO: begin
				mem_we = 1'b1;
			end
			MEM_WR_MAP: begin
				mem_we = 1'b1;
				wdata  = map_val;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= wdata;
		end
		if (mem_re) begin
			rd_q <= mem[addr];
		end
		if (cw.prod_ld) begin
			prod_q <= prod_full[ENTRY_W-1:0];
		end
		if (cw.sq_ld) begin
			sq_q <= SQ_W'(i_q) * SQ_W'(i_q);
		end
		if (accept) begin
			top_q <= eff_top;
			idx_q <= index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
			i_q <= '0;
		end else begin
			case (cw.j_op)
				J_ZERO:  j_q <= '0;
				J_TWO:   j_q <= J_W'(2);
				J_I:     j_q <= J_W'(i_q);
				J_SQ:    j_q <= sq_q;
				J_INC:   j_q <= j_q + 1'b1;
				J_ADDI:  j_q <= j_q + J_W'(i_q);
				J_ADDSQ: j_q <= j_q + sq_q;
				default: j_q <= j_q;
			endcase
			case (cw.i_op)
				I_TWO:   i_q <= I_W'(2);
				I_INC:   i_q <= i_q + 1'b1;
				default: i_q <= i_q;
			endcase
		end
	end

	assign flags.j_gt_top  = (j_q > top_ext);
	assign flags.sq_gt_top = (sq_q > top_ext);
	assign flags.not_one   = (rd_q != entry_t'(1));
	assign rd_value        = rd_q[1:0];

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !flags.j_gt_top)
		else $error("table write beyond the effective limit");

endmodule

FILE: design/moebius_table_sieve.sv
// Read: a transaction is taken while the sequencer is idle; a good read shows its result
// through the address, table read, result and output registers; the next transaction is
// taken once that result is in the output register. Rejected reads (not built, index beyond limit)
// skip the table. Build, on the single table port: fill every entry with 1, multiply the
// multiples of each prime p <= sqrt(L) by -p, zero those of p*p, fold 2 to L (effective limit).
// Reset: arst_n clears the sequencer, limit, built mark and output; the table is not cleared.
module moebius_table_sieve (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,   // limit
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // [15:0] index
	input  logic        s_tuser,     // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,     // [1:0] value, [7:2] zero
	output logic [1:0]  m_tuser      // [1:0] status
);
	import mts_pkg::*;

	cw_t              cw;
	dp_flags_t        flags;
	logic             idle;
	logic             accept;
	logic             out_free;
	logic [1:0]       disp;
	logic [1:0]       rd_value;
	logic [IDX_W-1:0] eff_top;

	logic [IDX_W-1:0] limit_q;
	logic             built_q;
	logic [1:0]       res_status_q;
	logic [1:0]       res_value_q;
	logic             out_valid_q;
	logic [1:0]       out_status_q;
	logic [1:0]       out_value_q;

	// Clamp the limit to the last table entry
	assign eff_top = (limit_q > IDX_W'(TOP_MAX)) ? IDX_W'(TOP_MAX) : limit_q;

	assign s_tready = idle;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// Route the transaction: build, table read, or an immediate status
	always_comb begin
		if (s_tuser == MODE_BUILD) begin
			disp = DISP_BUILD;
		end else if (!built_q || s_tdata > eff_top) begin
			disp = DISP_REJECT;
		end else begin
			disp = DISP_READ;
		end
	end

	mts_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.disp     (disp),
		.flags    (flags),
		.out_free (out_free),
		.cw       (cw),
		.idle     (idle)
	);

	mts_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cw       (cw),
		.accept   (accept),
		.index    (s_tdata),
		.eff_top  (eff_top),
		.flags    (flags),
		.rd_value (rd_value)
	);

	// Limit register and built mark; a limit write drops the mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
			built_q <= 1'b0;
		end else if (cfg_wen) begin
			limit_q <= cfg_wdata;
			built_q <= 1'b0;
		end else if (cw.res == RES_BUILD) begin
			built_q <= 1'b1;
		end
	end

	// Pending result, held until the output register takes it
	always_ff @(posedge clk) begin
		if (accept && disp == DISP_REJECT) begin
			res_status_q <= built_q ? STAT_RANGE : STAT_UNBUILT;
			res_value_q  <= '0;
		end else if (cw.res == RES_BUILD) begin
			res_status_q <= STAT_BUILT;
			res_value_q  <= '0;
		end else if (cw.res == RES_READ) begin
			res_status_q <= STAT_OK;
			res_value_q  <= rd_value;
		end
	end

	// Output register: advance when the sink takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.emit && out_free) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_value_q};
	assign m_tuser  = out_status_q;

	a_built_from_program: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(built_q) |-> $past(cw.res == RES_BUILD))
		else $error("built mark set outside the end of a build");

	a_emit_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.emit && out_free) |=> out_valid_q)
		else $error("result dropped on its way to the output register");

	a_idle_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !cw.emit)
		else $error("input ready while a result is being emitted");

endmodule

FILE: tb/moebius_table_sieve_test.sv
module moebius_table_sieve_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mts_pkg::*;

	// Stop a hung run. The full-range build alone sieves all 65536 entries,
	// so allow the slowest correct run many times over.
	localparam int unsigned CYCLE_LIMIT  = 10_000_000;
	localparam int unsigned IDLE_PERCENT = 37;
	localparam int unsigned HOLD_CYCLES  = 300;

	// One expected reply, with the request kept alongside for mismatch reports
	typedef struct packed {
		logic        mode;
		logic [15:0] idx;
		logic [1:0]  value;
		logic [1:0]  status;
	} mobius_reply_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;    // [15:0] index
	logic        s_tuser = 1'b0;  // [0] mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // [1:0] value, [7:2] zero
	logic [1:0]  m_tuser;         // [1:0] status

	// Predictor state: our own copy of the limit register, built mark and sieve store
	logic [15:0]   limit_reg = '0;
	logic          table_ready = 1'b0;
	int            mobius_work [0:TOP_MAX];
	mobius_reply_t pending_replies [$];
	mobius_reply_t want;

	// Idling control: steady suppresses random gaps on both sides; a change of
	// hold_ticket asks the receiver for one long hold-off
	logic        steady = 1'b0;
	int unsigned hold_ticket = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;

	int unsigned cycle_count = 0;
	int unsigned errors = 0;
	int unsigned n_builds = 0;
	int unsigned n_good = 0;
	int unsigned n_range = 0;
	int unsigned n_unbuilt = 0;

	moebius_table_sieve u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sieve the predictor's store up to the effective limit: start every entry
	// at 1, multiply multiples of each surviving i by -i, zero multiples of i
	// squared, then fold each entry from 2 up into its Moebius value.
	function automatic void run_sieve();
		int top;
		int root;
		int p;
		int m;
		top = (limit_reg < TOP_MAX) ? limit_reg : TOP_MAX;
		root = 0;
		while ((root + 1) * (root + 1) <= top)
			root++;
		for (m = 0; m <= top; m++)
			mobius_work[m] = 1;
		for (p = 2; p <= root; p++) begin
			if (mobius_work[p] == 1) begin
				for (m = p; m <= top; m += p)
					mobius_work[m] = mobius_work[m] * -p;
				for (m = p * p; m <= top; m += p * p)
					mobius_work[m] = 0;
			end
		end
		for (m = 2; m <= top; m++) begin
			if (mobius_work[m] == m)
				mobius_work[m] = 1;
			else if (mobius_work[m] == -m)
				mobius_work[m] = -1;
			else if (mobius_work[m] < 0)
				mobius_work[m] = 1;
			else if (mobius_work[m] > 0)
				mobius_work[m] = -1;
		end
		table_ready = 1'b1;
	endfunction

	// Work out the reply to one accepted transaction; a build updates the store
	function automatic mobius_reply_t predict_reply(input logic mode, input logic [15:0] idx);
		mobius_reply_t r;
		int top;
		int entry;
		r.mode   = mode;
		r.idx    = idx;
		r.value  = 2'b00;
		top = (limit_reg < TOP_MAX) ? limit_reg : TOP_MAX;
		if (mode == MODE_BUILD) begin
			run_sieve();
			r.status = STAT_BUILT;
		end else if (!table_ready) begin
			r.status = STAT_UNBUILT;
		end else if (idx > top) begin
			r.status = STAT_RANGE;
		end else begin
			entry   = mobius_work[idx];
			r.value = entry[1:0];
			r.status = STAT_OK;
		end
		return r;
	endfunction

	// Offer one item and hold it until the block takes it. Random gaps go in front;
	// valid is only lowered inside a gap, so back-to-back items keep it high.
	task automatic send_item(input logic mode, input logic [15:0] idx);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= idx;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_replies = {pending_replies, predict_reply(mode, idx)};
	endtask

	// Drop valid and wait for every outstanding reply, plus a short settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write the limit only once the block has gone quiet; any write clears the built mark
	task automatic set_limit(input logic [15:0] lim);
		wait_drained();
		cfg_wen   <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_wen     <= 1'b0;
		limit_reg   = lim;
		table_ready = 1'b0;
	endtask

	// Reads straight out of reset must report an unbuilt table, even far beyond the limit
	task automatic test_before_build();
		send_item(MODE_READ, 16'd0);
		send_item(MODE_READ, 16'hFFFF);
		send_item(MODE_READ, 16'h5555);
	endtask

	// Limit zero after reset: build a one-entry table; the build ignores its index bits
	task automatic test_limit_zero();
		send_item(MODE_BUILD, 16'hFFFF);
		send_item(MODE_READ, 16'd0);
		send_item(MODE_READ, 16'd1);
		send_item(MODE_READ, 16'hFFFF);
	endtask

	// Tiny tables: entries 0 and 1, primes, squares, square-free products and the edge
	task automatic test_small_limits();
		set_limit(16'd1);
		send_item(MODE_BUILD, 16'd0);
		send_item(MODE_READ, 16'd0);
		send_item(MODE_READ, 16'd1);
		send_item(MODE_READ, 16'd2);
		set_limit(16'd36);
		send_item(MODE_READ, 16'd5);
		send_item(MODE_BUILD, 16'h2AAA);
		send_item(MODE_READ, 16'd1);
		send_item(MODE_READ, 16'd2);
		send_item(MODE_READ, 16'd4);
		send_item(MODE_READ, 16'd6);
		send_item(MODE_READ, 16'd30);
		send_item(MODE_READ, 16'd35);
		send_item(MODE_READ, 16'd36);
		send_item(MODE_READ, 16'd37);
	endtask

	// Random tables of modest size. Each phase probes the unbuilt state, builds,
	// then reads mostly within the limit, with some just beyond, some anywhere
	// and the odd rebuild in the middle of the stream.
	task automatic test_random_tables();
		int unsigned phase;
		int unsigned n;
		int unsigned pick;
		int unsigned lim;
		for (phase = 0; phase < 8; phase++) begin
			steady <= (phase == 3);
			lim = (phase == 5) ? $urandom_range(0, 3) : $urandom_range(4, 700);
			set_limit(16'(lim));
			repeat ($urandom_range(1, 3))
				send_item(MODE_READ, 16'($urandom));
			send_item(MODE_BUILD, 16'($urandom));
			for (n = 0; n < 135; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 3)
					send_item(MODE_BUILD, 16'($urandom));
				else if (pick < 83)
					send_item(MODE_READ, 16'($urandom_range(0, lim)));
				else if (pick < 91)
					send_item(MODE_READ, 16'(lim + $urandom_range(1, 8)));
				else
					send_item(MODE_READ, 16'($urandom));
			end
		end
		steady <= 1'b0;
	endtask

	// Hold the receiver off for a long stretch while the sender keeps offering,
	// so replies back up and the block stalls its input
	task automatic test_backpressure();
		int unsigned n;
		wait_drained();
		steady      <= 1'b1;
		hold_ticket <= hold_ticket + 1;
		for (n = 0; n < 40; n++)
			send_item(MODE_READ, 16'($urandom_range(0, limit_reg + 4)));
		steady <= 1'b0;
	endtask

	// Largest limit: one full-range build, then reads across the whole index space
	task automatic test_full_table();
		int unsigned n;
		set_limit(16'hFFFF);
		send_item(MODE_READ, 16'($urandom));
		send_item(MODE_READ, 16'hFFFF);
		send_item(MODE_BUILD, 16'($urandom));
		send_item(MODE_READ, 16'hFFFF);
		send_item(MODE_READ, 16'hFFFE);
		send_item(MODE_READ, 16'd0);
		for (n = 0; n < 77; n++)
			send_item(MODE_READ, 16'($urandom));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_before_build();
		test_limit_zero();
		test_small_limits();
		test_random_tables();
		test_backpressure();
		test_full_table();
		wait_drained();
		// Wait on so that any stray reply can surface
		repeat (50) @(posedge clk);
		$display("covered %0d builds and %0d reads: %0d good, %0d beyond limit, %0d unbuilt",
			n_builds, n_good + n_range + n_unbuilt, n_good, n_range, n_unbuilt);
		$display("limits written ranged from 0 to 65535, with long stalls on both sides");
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Receiver: check each reply transaction against the oldest expectation,
	// then choose ready for the next cycle (random, steady or held off)
	always @(posedge clk) begin
		cycle_count++;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				errors++;
				$display("%0t: reply with nothing expected: expected none, got data %h status %0d",
					$time, m_tdata, m_tuser);
			end else begin
				want = pending_replies.pop_front();
				if (m_tdata !== {6'b0, want.value} || m_tuser !== want.status) begin
					errors++;
					$display("%0t: mode %0d index %0d: expected data %h status %0d, %s %h status %0d",
						$time, want.mode, want.idx, {6'b0, want.value}, want.status,
						"got data", m_tdata, m_tuser);
				end
				case (want.status)
					STAT_BUILT: begin
						n_builds++;
					end
					STAT_OK: begin
						n_good++;
					end
					STAT_RANGE: begin
						n_range++;
					end
					default: begin
						n_unbuilt++;
					end
				endcase
			end
		end
		if (hold_served != hold_ticket) begin
			hold_served = hold_ticket;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d replies outstanding",
				cycle_count, pending_replies.size());
			$display("status: fail");
			$finish;
		end
	end

endmodule
